/* src/vlerb_pkg.sv */
// Shared constants, codes and controller/datapath handshake types for the event ring buffer.
package vlerb_pkg;

  localparam int BUFFER_WORDS_DEF    = 256;
  localparam int MAX_EVENT_WORDS_DEF = 16;
  localparam int WORD_BYTES          = 4;
  localparam int LANE_W              = $clog2(WORD_BYTES);
  localparam int DATA_W              = 32;
  localparam int BYTES_W             = 7;
  localparam int STATUS_W            = 4;
  localparam int CMD_W               = 2;
  localparam int CFG_IDX_W           = 2;

  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_RESERVED     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED      = 4'd1;
  localparam logic [STATUS_W-1:0] ST_FULL_RETRY   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_WORD_STORED  = 4'd4;
  localparam logic [STATUS_W-1:0] ST_NO_OPEN      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_EVENT_WORD   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_BUFFER_EMPTY = 4'd7;
  localparam logic [STATUS_W-1:0] ST_TICK_DONE    = 4'd8;
  localparam logic [STATUS_W-1:0] ST_ALREADY_OPEN = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_PADDING   = 2'd2;

  localparam logic [BYTES_W-1:0] MAX_EVENT_BYTES_RST = 7'd64;
  localparam logic [31:0]        FLUSH_PERIOD_RST    = 32'd1000;
  localparam logic [31:0]        FLUSH_PADDING_RST   = 32'd50;

  typedef struct packed {
    logic clear_wr;
    logic capture;
    logic exec;
    logic hdr_wr;
    logic hdr_rd;
    logic drain_empty;
    logic drain_start;
    logic word_rd;
    logic word_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic             clear_done;
    logic [CMD_W-1:0] item_cmd;
    logic             data_open;
    logic             need_hdr;
    logic             hdr_zero;
    logic             drain_last;
    logic             out_free;
  } dp_stat_t;

endpackage

/* src/vlerb_intf.sv */
// Channel interfaces for the input, result and configuration ports.
interface vlerb_in_if;
  logic                               valid;
  logic                               ready;
  logic [vlerb_pkg::CMD_W-1:0]        command;
  logic [vlerb_pkg::BYTES_W-1:0]      event_bytes;
  logic [vlerb_pkg::DATA_W-1:0]       data_word;

  modport source (output valid, command, event_bytes, data_word, input ready);
  modport sink   (input valid, command, event_bytes, data_word, output ready);
endinterface

interface vlerb_out_if;
  logic                               valid;
  logic                               ready;
  logic [vlerb_pkg::STATUS_W-1:0]     status;
  logic [vlerb_pkg::DATA_W-1:0]       out_word;
  logic [vlerb_pkg::BYTES_W-1:0]      out_bytes;
  logic                               last_word;
  logic                               flush_request;

  modport source (output valid, status, out_word, out_bytes, last_word, flush_request,
                  input ready);
  modport sink   (input valid, status, out_word, out_bytes, last_word, flush_request,
                  output ready);
endinterface

interface vlerb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [vlerb_pkg::CFG_IDX_W-1:0]    index;
  logic [31:0]                        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/vlerb_ctrl.sv */
// Controller state machine that sequences clearing, command execution and event drain.
module vlerb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  vlerb_pkg::dp_stat_t   stat,
  output vlerb_pkg::ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_HDR   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.item_cmd == vlerb_pkg::CMD_DRAIN) begin
          cmd.hdr_rd = 1'b1;
          state_nxt  = S_CHK;
        end else if (stat.out_free) begin
          cmd.exec = 1'b1;
          // The last data word of an event still owes the header write.
          if (stat.item_cmd == vlerb_pkg::CMD_DATA && stat.data_open && stat.need_hdr)
            state_nxt = S_HDR;
          else
            state_nxt = S_IDLE;
        end
      end
      S_HDR: begin
        cmd.hdr_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CHK: begin
        if (stat.hdr_zero) begin
          if (stat.out_free) begin
            cmd.drain_empty = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd.drain_start = 1'b1;
          state_nxt       = S_RDW;
        end
      end
      S_RDW: begin
        cmd.word_rd = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.word_emit = 1'b1;
          state_nxt     = stat.drain_last ? S_IDLE : S_RDW;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

/* src/vlerb_dp.sv */
// Datapath: event store memory, ring pointers, open-event and flush state, output register.
module vlerb_dp #(
  parameter int BUFFER_WORDS    = vlerb_pkg::BUFFER_WORDS_DEF,
  parameter int MAX_EVENT_WORDS = vlerb_pkg::MAX_EVENT_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vlerb_pkg::ctrl_cmd_t              cmd,
  output vlerb_pkg::dp_stat_t               stat,
  input  logic [vlerb_pkg::CMD_W-1:0]       in_command,
  input  logic [vlerb_pkg::BYTES_W-1:0]     in_event_bytes,
  input  logic [vlerb_pkg::DATA_W-1:0]      in_data_word,
  input  logic                              cfg_valid,
  input  logic [vlerb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [vlerb_pkg::STATUS_W-1:0]    out_status,
  output logic [vlerb_pkg::DATA_W-1:0]      out_word,
  output logic [vlerb_pkg::BYTES_W-1:0]     out_bytes,
  output logic                              out_last_word,
  output logic                              out_flush_request
);

  localparam int STORE_WORDS = BUFFER_WORDS + MAX_EVENT_WORDS;
  localparam int AW          = $clog2(STORE_WORDS);
  localparam int PW          = $clog2(BUFFER_WORDS);
  localparam int SW          = AW + 1;
  localparam int WFW         = $clog2(MAX_EVENT_WORDS + 1);
  localparam int LIMIT_BYTES = MAX_EVENT_WORDS * vlerb_pkg::WORD_BYTES;
  localparam int HALF        = BUFFER_WORDS / 2;
  localparam int MOD_STEPS   = 1 + MAX_EVENT_WORDS / BUFFER_WORDS;
  localparam int WB          = vlerb_pkg::WORD_BYTES;
  localparam int LW          = vlerb_pkg::LANE_W;
  localparam int LANES       = vlerb_pkg::DATA_W / 8;
  localparam int DW          = vlerb_pkg::DATA_W;
  localparam int BW7         = vlerb_pkg::BYTES_W;
  localparam int STW         = vlerb_pkg::STATUS_W;

  function automatic logic crosses(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                   input logic [PW-1:0] c);
    logic [1:0] n;
    n = 2'(a < c) + 2'(c <= b) + 2'(b < a);
    return n == 2'd2;
  endfunction

  // Storage and registers.
  logic [DW-1:0]  mem [STORE_WORDS];
  logic [DW-1:0]  rd_data_r;
  logic [AW-1:0]  clr_cnt_r;

  logic [vlerb_pkg::CMD_W-1:0] item_cmd_r;
  logic [BW7-1:0] item_bytes_r;
  logic [DW-1:0]  item_word_r;

  logic [PW-1:0]  rp_r, rp_nxt;
  logic [PW-1:0]  wp_r, wp_nxt;
  logic           open_r, open_nxt;
  logic [PW-1:0]  open_start_r, open_start_nxt;
  logic [BW7-1:0] open_size_r, open_size_nxt;
  logic [WFW-1:0] wf_r, wf_nxt;
  logic           flush_r, flush_nxt;
  logic [31:0]    tsf_r, tsf_nxt;

  logic [BW7-1:0] max_bytes_r;
  logic [31:0]    period_r;
  logic [31:0]    padding_r;

  logic [WFW-1:0] drain_n_r;
  logic [WFW-1:0] drain_i_r;
  logic [BW7-1:0] drain_size_r;

  logic           out_valid_r;
  logic [STW-1:0] out_status_r;
  logic [DW-1:0]  out_word_r;
  logic [BW7-1:0] out_bytes_r;
  logic           out_last_r;
  logic           out_flush_r;

  // Memory port controls.
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [DW-1:0]  mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;

  // Begin arithmetic.
  logic [7:0]     b_total;
  logic           b_too_large;
  logic [SW-1:0]  b_sum;
  logic [PW-1:0]  b_next;
  logic [SW-1:0]  h_sum;
  logic [PW-1:0]  h_mark;

  // Data arithmetic.
  logic [WFW-1:0] d_n;
  logic           d_last;
  logic [AW-1:0]  d_idx;
  logic [LW-1:0]  d_rem;
  logic [DW-1:0]  d_word;

  // Drain arithmetic.
  logic [DW:0]    z_words;
  logic [WFW-1:0] z_n;
  logic [AW-1:0]  w_addr;
  logic           z_last;
  logic [SW-1:0]  rp_adv;

  // Tick arithmetic.
  logic [31:0]    t_inc;
  logic [31:0]    t_remain;

  // Output load.
  logic           out_load;
  logic [STW-1:0] ost;
  logic [DW-1:0]  oword;
  logic [BW7-1:0] obytes;
  logic           olast;

  assign b_total     = 8'd1 + 8'((9'(item_bytes_r) + 9'(WB - 1)) / WB);
  assign b_too_large = (item_bytes_r > max_bytes_r) ||
                       (32'(item_bytes_r) > 32'(LIMIT_BYTES)) ||
                       (32'(b_total) >= 32'(BUFFER_WORDS));
  assign b_sum       = SW'(wp_r) + SW'(b_total);
  assign b_next      = (b_sum >= SW'(BUFFER_WORDS)) ? PW'(b_sum - SW'(BUFFER_WORDS))
                                                    : PW'(b_sum);
  assign h_sum       = SW'(rp_r) + SW'(HALF);
  assign h_mark      = (h_sum >= SW'(BUFFER_WORDS)) ? PW'(h_sum - SW'(BUFFER_WORDS))
                                                    : PW'(h_sum);

  assign d_n    = WFW'((9'(open_size_r) + 9'(WB - 1)) / WB);
  assign d_last = (WFW + 1)'(wf_r) + (WFW + 1)'(1) >= (WFW + 1)'(d_n);
  assign d_idx  = AW'(open_start_r) + AW'(wf_r) + AW'(1);
  assign d_rem  = open_size_r[LW-1:0];

  // Bytes past the event size in a partial last word are stored as zero.
  always_comb begin
    d_word = item_word_r;
    if (d_last && d_rem != '0) begin
      for (int k = 0; k < LANES; k++) begin
        if (LW'(k) >= d_rem) d_word[8*k +: 8] = 8'd0;
      end
    end
  end

  assign z_words = ({1'b0, rd_data_r} + (DW + 1)'(WB - 1)) / WB;
  assign z_n     = (z_words > (DW + 1)'(MAX_EVENT_WORDS)) ? WFW'(MAX_EVENT_WORDS) :
                   (z_words == '0) ? WFW'(1) : WFW'(z_words);
  assign w_addr  = AW'(rp_r) + AW'(drain_i_r) + AW'(1);
  assign z_last  = (WFW + 1)'(drain_i_r) + (WFW + 1)'(1) == (WFW + 1)'(drain_n_r);

  always_comb begin
    rp_adv = SW'(rp_r) + SW'(drain_n_r) + SW'(1);
    for (int s = 0; s < MOD_STEPS; s++) begin
      if (rp_adv >= SW'(BUFFER_WORDS)) rp_adv = rp_adv - SW'(BUFFER_WORDS);
    end
  end

  assign t_inc    = (tsf_r == '1) ? tsf_r : tsf_r + 32'd1;
  assign t_remain = (period_r > t_inc) ? period_r - t_inc : 32'd0;

  // Item execution and ring state updates.
  always_comb begin
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    open_nxt       = open_r;
    open_start_nxt = open_start_r;
    open_size_nxt  = open_size_r;
    wf_nxt         = wf_r;
    flush_nxt      = flush_r;
    tsf_nxt        = tsf_r;
    out_load       = 1'b0;
    ost            = vlerb_pkg::ST_TICK_DONE;
    oword          = '0;
    obytes         = '0;
    olast          = 1'b0;

    if (cmd.exec) begin
      out_load = 1'b1;
      case (item_cmd_r)
        vlerb_pkg::CMD_BEGIN: begin
          if (open_r) begin
            ost = vlerb_pkg::ST_ALREADY_OPEN;
          end else if (b_too_large) begin
            ost = vlerb_pkg::ST_TOO_LARGE;
          end else if (item_bytes_r == '0) begin
            ost = vlerb_pkg::ST_DROPPED;
          end else if (crosses(wp_r, b_next, rp_r)) begin
            ost       = vlerb_pkg::ST_FULL_RETRY;
            flush_nxt = 1'b1;
          end else begin
            ost            = vlerb_pkg::ST_RESERVED;
            flush_nxt      = flush_r | crosses(wp_r, b_next, h_mark);
            open_nxt       = 1'b1;
            open_start_nxt = wp_r;
            open_size_nxt  = item_bytes_r;
            wf_nxt         = '0;
            wp_nxt         = b_next;
          end
        end
        vlerb_pkg::CMD_DATA: begin
          if (!open_r) begin
            ost = vlerb_pkg::ST_NO_OPEN;
          end else begin
            ost = vlerb_pkg::ST_WORD_STORED;
            if (d_last) begin
              open_nxt = 1'b0;
              wf_nxt   = '0;
            end else begin
              wf_nxt = wf_r + WFW'(1);
            end
          end
        end
        vlerb_pkg::CMD_TICK: begin
          ost     = vlerb_pkg::ST_TICK_DONE;
          tsf_nxt = t_inc;
          if (t_remain < padding_r) flush_nxt = 1'b1;
        end
        default: begin
          out_load = 1'b0;
        end
      endcase
    end else if (cmd.drain_empty) begin
      out_load  = 1'b1;
      ost       = vlerb_pkg::ST_BUFFER_EMPTY;
      flush_nxt = 1'b0;
      tsf_nxt   = '0;
    end else if (cmd.word_emit) begin
      out_load = 1'b1;
      ost      = vlerb_pkg::ST_EVENT_WORD;
      oword    = rd_data_r;
      obytes   = drain_size_r;
      olast    = z_last;
      if (z_last) rp_nxt = PW'(rp_adv);
    end
  end

  // One write and one read address per cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd.exec && item_cmd_r == vlerb_pkg::CMD_DATA && open_r) begin
      mem_we    = 1'b1;
      mem_waddr = d_idx;
      mem_wdata = d_word;
    end else if (cmd.hdr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(open_start_r);
      mem_wdata = DW'(open_size_r);
    end else if (cmd.drain_start) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(rp_r);
    end else if (cmd.word_emit) begin
      mem_we    = 1'b1;
      mem_waddr = w_addr;
    end
  end

  assign mem_re    = cmd.hdr_rd | cmd.word_rd;
  assign mem_raddr = cmd.hdr_rd ? AW'(rp_r) : w_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  // Control and ring state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      rp_r         <= '0;
      wp_r         <= '0;
      open_r       <= 1'b0;
      open_start_r <= '0;
      open_size_r  <= '0;
      wf_r         <= '0;
      flush_r      <= 1'b0;
      tsf_r        <= '0;
      max_bytes_r  <= vlerb_pkg::MAX_EVENT_BYTES_RST;
      period_r     <= vlerb_pkg::FLUSH_PERIOD_RST;
      padding_r    <= vlerb_pkg::FLUSH_PADDING_RST;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_cnt_r <= clr_cnt_r + AW'(1);
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      open_r       <= open_nxt;
      open_start_r <= open_start_nxt;
      open_size_r  <= open_size_nxt;
      wf_r         <= wf_nxt;
      flush_r      <= flush_nxt;
      tsf_r        <= tsf_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          vlerb_pkg::CFG_MAX_EVENT_BYTES: max_bytes_r <= cfg_data[BW7-1:0];
          vlerb_pkg::CFG_FLUSH_PERIOD:    period_r    <= cfg_data;
          vlerb_pkg::CFG_FLUSH_PADDING:   padding_r   <= cfg_data;
          default: ;
        endcase
      end
      if (out_load)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd_r   <= in_command;
      item_bytes_r <= in_event_bytes;
      item_word_r  <= in_data_word;
    end
    if (cmd.drain_start) begin
      drain_n_r    <= z_n;
      drain_i_r    <= '0;
      drain_size_r <= rd_data_r[BW7-1:0];
    end else if (cmd.word_emit) begin
      drain_i_r <= drain_i_r + WFW'(1);
    end
    if (out_load) begin
      out_status_r <= ost;
      out_word_r   <= oword;
      out_bytes_r  <= obytes;
      out_last_r   <= olast;
      out_flush_r  <= flush_nxt;
    end
  end

  assign stat.clear_done = (clr_cnt_r == AW'(STORE_WORDS - 1));
  assign stat.item_cmd   = item_cmd_r;
  assign stat.data_open  = open_r;
  assign stat.need_hdr   = d_last;
  assign stat.hdr_zero   = (rd_data_r == '0);
  assign stat.drain_last = z_last;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_word          = out_word_r;
  assign out_bytes         = out_bytes_r;
  assign out_last_word     = out_last_r;
  assign out_flush_request = out_flush_r;

endmodule

/* src/variable_length_event_ring_buffer_top.sv */
// Top level of the variable-length event ring buffer: controller, datapath and checks.
//
// The input channel takes one command word at a time: begin an event, store one data
// word, drain one event, or a time tick. The result channel returns one word per
// command, except that draining a published event returns one word per data word,
// with last_word set on the final one. The configuration channel is always ready and
// writes max_event_bytes, flush_period_ticks and flush_padding_ticks by index.
// A command word is accepted only while the block is idle. Begin, tick and a data
// word are executed once the output register is free and their result is valid in
// the next cycle; a data word that completes its event then writes the header.
// A drain reads the header at the read pointer, then reads, returns and clears each
// data word in turn; the event store has one write port and one read port. After
// reset the whole store, BUFFER_WORDS plus MAX_EVENT_WORDS words (272 by default),
// is cleared one word per cycle, and no command word is taken meanwhile. Results sit
// in an output register: a new command word is taken while a result waits, and a
// receiver that stalls holds the block at the point where the next result is due.
module variable_length_event_ring_buffer_top #(
  parameter int BUFFER_WORDS    = vlerb_pkg::BUFFER_WORDS_DEF,
  parameter int MAX_EVENT_WORDS = vlerb_pkg::MAX_EVENT_WORDS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  vlerb_in_if.sink    in_ch,
  vlerb_out_if.source out_ch,
  vlerb_cfg_if.sink   cfg_ch
);

  vlerb_pkg::ctrl_cmd_t cmd;
  vlerb_pkg::dp_stat_t  stat;
  logic                 in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  vlerb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vlerb_dp #(
    .BUFFER_WORDS    (BUFFER_WORDS),
    .MAX_EVENT_WORDS (MAX_EVENT_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_ch.command),
    .in_event_bytes    (in_ch.event_bytes),
    .in_data_word      (in_ch.data_word),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_word          (out_ch.out_word),
    .out_bytes         (out_ch.out_bytes),
    .out_last_word     (out_ch.last_word),
    .out_flush_request (out_ch.flush_request)
  );

`ifndef ASSERT_OFF
  // No command word is taken while the clearing pass still owns the store.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_wr |-> !in_ch.ready)
    else $error("command word accepted during clearing pass");

  // The store has one write port: at most one of the clear, header, drain-start and emit writes per cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_wr, cmd.hdr_wr, cmd.drain_start, cmd.word_emit}))
    else $error("more than one store write in a cycle");

  // Each drained word lands in the output register as an event word.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.word_emit |=> out_ch.valid && out_ch.status == vlerb_pkg::ST_EVENT_WORD)
    else $error("drained word not presented");

  // A drain of an empty buffer reports empty with the flush request dropped.
  a_empty_clears_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain_empty |=> out_ch.valid && !out_ch.flush_request &&
                        out_ch.status == vlerb_pkg::ST_BUFFER_EMPTY)
    else $error("empty drain result wrong");
`endif

endmodule
